[hdl/evr_pkg.sv]
package evr_pkg;

  // atan(2^-i) in units where 2^32 is a full turn, rounded to nearest.
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // CORDIC gain compensation in Q2.30.
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  // Components between axes: clamped to +-(2^32 - 1), so 34 bits signed.
  localparam int CW = 34;
  // Sine and cosine in Q2.30 with headroom.
  localparam int SW = 34;

  localparam logic signed [CW-1:0] MID_LIM = 34'sd4294967295;

  typedef struct packed {
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] cx;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] cy;
    logic signed [SW-1:0] sz;
    logic signed [SW-1:0] cz;
  } trig_t;

endpackage

[hdl/evr_cordic.sv]
module evr_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [15:0]           angle,
  output logic signed [evr_pkg::SW-1:0] sin_o,
  output logic signed [evr_pkg::SW-1:0] cos_o
);

  localparam int SW = evr_pkg::SW;

  logic signed [SW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [SW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [32:0]   z_r [CORDIC_STEPS+1];
  logic                 f_r [CORDIC_STEPS+1];

  logic [31:0] a_full;
  logic        flip;
  logic [31:0] a_adj;

  always_comb begin
    a_full = {angle, 16'h0000};
    flip   = a_full[31] ^ a_full[30];
    a_adj  = flip ? a_full + 32'h80000000 : a_full;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= evr_pkg::GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= {a_adj[31], a_adj};
      f_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [32:0] T = {1'b0, evr_pkg::ATAN_TURN[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][32]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - T;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + T;
        end
        f_r[i+1] <= f_r[i];
      end
    end
  end

  assign cos_o = f_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
  assign sin_o = f_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];

endmodule

[hdl/evr_turn.sv]
module evr_turn (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [evr_pkg::CW-1:0] a,
  input  logic signed [evr_pkg::CW-1:0] b,
  input  logic signed [evr_pkg::SW-1:0] s,
  input  logic signed [evr_pkg::SW-1:0] c,
  output logic signed [evr_pkg::CW-1:0] na,
  output logic signed [evr_pkg::CW-1:0] nb
);

  localparam int CW = evr_pkg::CW;
  localparam int PW = 2 * evr_pkg::CW + 2;

  logic signed [PW-1:0] ac_r, bs_r, as_r, bc_r;
  logic signed [PW-1:0] sa, sb, ra, rb;

  // Stage one: the four products.
  always_ff @(posedge clk) begin
    if (en) begin
      ac_r <= PW'(a * c);
      bs_r <= PW'(b * s);
      as_r <= PW'(a * s);
      bc_r <= PW'(b * c);
    end
  end

  always_comb begin
    sa = ac_r - bs_r + (PW'(1) <<< 29);
    sb = as_r + bc_r + (PW'(1) <<< 29);
    ra = sa >>> 30;
    rb = sb >>> 30;
  end

  // Stage two: sum, round and clamp.
  always_ff @(posedge clk) begin
    if (en) begin
      na <= (ra > PW'(evr_pkg::MID_LIM)) ? evr_pkg::MID_LIM :
            (ra < -PW'(evr_pkg::MID_LIM)) ? -evr_pkg::MID_LIM : CW'(ra);
      nb <= (rb > PW'(evr_pkg::MID_LIM)) ? evr_pkg::MID_LIM :
            (rb < -PW'(evr_pkg::MID_LIM)) ? -evr_pkg::MID_LIM : CW'(rb);
    end
  end

endmodule

[hdl/euler_vector_rotation.sv]
// Euler-angle rotation of a Q16.16 3D vector.
// Input channel: in_valid / in_stall with vec_x/y/z (Q16.16) and angle_x/y/z
// (binary angles, 32768 = pi). A transfer happens when valid is high and
// stall is low. Result channel: out_valid / out_stall with rot_x/y/z,
// saturated to the Q16.16 range; one result per input transfer, in order.
// Configuration: cfg_valid / cfg_ready write rotation_order (cfg_data[0]);
// 0 rotates about X, Y, Z in turn, 1 about Z, Y, X. Write it only when idle.
// Throughput: one item per cycle while the result side does not stall. From
// input transfer to out_valid, data passes the sine/cosine CORDIC pipeline (one
// register per iteration), then three rotation units of two stages each
// (products, then round/clamp) and one output register.
// The whole pipeline advances only when the output register is free or being
// taken, so a stall on the result side holds every stage and in_stall rises
// with it; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and rotation_order.
module euler_vector_rotation #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int CW    = evr_pkg::CW;
  localparam int CLAT  = CORDIC_STEPS + 1;   // CORDIC pipeline depth
  localparam int DEPTH = CLAT + 6 + 1;       // total valid-bit pipeline

  logic order_r;
  logic adv;
  logic [DEPTH-1:0] vld_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      order_r <= cfg_data;
    end
  end

  // The pipeline moves when the output slot is empty or being taken.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // Sine and cosine for the three axes.
  evr_pkg::trig_t trig;

  evr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cx (
    .clk(clk), .en(adv), .angle(in_angle_x), .sin_o(trig.sx), .cos_o(trig.cx));
  evr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cy (
    .clk(clk), .en(adv), .angle(in_angle_y), .sin_o(trig.sy), .cos_o(trig.cy));
  evr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cz (
    .clk(clk), .en(adv), .angle(in_angle_z), .sin_o(trig.sz), .cos_o(trig.cz));

  // Vector delay line matching the CORDIC depth.
  logic signed [CW-1:0] vx_r [CLAT];
  logic signed [CW-1:0] vy_r [CLAT];
  logic signed [CW-1:0] vz_r [CLAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r[0] <= CW'(in_vec_x);
      vy_r[0] <= CW'(in_vec_y);
      vz_r[0] <= CW'(in_vec_z);
      for (int i = 1; i < CLAT; i++) begin
        vx_r[i] <= vx_r[i-1];
        vy_r[i] <= vy_r[i-1];
        vz_r[i] <= vz_r[i-1];
      end
    end
  end

  // Trig values are held for the two later rotations.
  evr_pkg::trig_t trig1_r, trig2_r;
  logic ord0_r, ord1_r, ord2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      trig1_r <= trig;
      trig2_r <= trig1_r;
      ord0_r  <= order_r;
      ord1_r  <= ord0_r;
      ord2_r  <= ord1_r;
    end
  end

  logic signed [CW-1:0] vx0, vy0, vz0;
  assign vx0 = vx_r[CLAT-1];
  assign vy0 = vy_r[CLAT-1];
  assign vz0 = vz_r[CLAT-1];

  // Rotation one: X (order 0) or Z (order 1).
  logic signed [CW-1:0] a1, b1, s1, c1, na1, nb1;
  logic signed [CW-1:0] p1x_r [2], p1z_r [2];
  always_comb begin
    if (!order_r) begin
      a1 = vy0; b1 = vz0; s1 = trig.sx; c1 = trig.cx;
    end else begin
      a1 = vx0; b1 = vy0; s1 = trig.sz; c1 = trig.cz;
    end
  end
  evr_turn u_t1 (.clk(clk), .en(adv), .a(a1), .b(b1), .s(s1), .c(c1),
                 .na(na1), .nb(nb1));
  always_ff @(posedge clk) begin
    if (adv) begin
      p1x_r[0] <= vx0; p1z_r[0] <= vz0;
      p1x_r[1] <= p1x_r[0]; p1z_r[1] <= p1z_r[0];
    end
  end
  logic signed [CW-1:0] x1, y1, z1;
  always_comb begin
    if (!ord1_r) begin
      x1 = p1x_r[1]; y1 = na1; z1 = nb1;
    end else begin
      x1 = na1; y1 = nb1; z1 = p1z_r[1];
    end
  end

  // Rotation two: Y for both orders, pair (z, x).
  logic signed [CW-1:0] na2, nb2;
  logic signed [CW-1:0] p2y_r [2];
  evr_turn u_t2 (.clk(clk), .en(adv), .a(z1), .b(x1), .s(trig2_r.sy),
                 .c(trig2_r.cy), .na(na2), .nb(nb2));
  evr_pkg::trig_t trig3_r, trig4_r;
  logic ord3_r, ord4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p2y_r[0] <= y1; p2y_r[1] <= p2y_r[0];
      trig3_r <= trig2_r; trig4_r <= trig3_r;
      ord3_r <= ord2_r; ord4_r <= ord3_r;
    end
  end
  logic signed [CW-1:0] x2, y2, z2;
  assign z2 = na2;
  assign x2 = nb2;
  assign y2 = p2y_r[1];

  // Rotation three: Z (order 0) or X (order 1).
  logic signed [CW-1:0] a3, b3, s3, c3, na3, nb3;
  logic signed [CW-1:0] p3x_r [2], p3z_r [2];
  logic ord5_r, ord6_r;
  always_comb begin
    if (!ord4_r) begin
      a3 = x2; b3 = y2; s3 = trig4_r.sz; c3 = trig4_r.cz;
    end else begin
      a3 = y2; b3 = z2; s3 = trig4_r.sx; c3 = trig4_r.cx;
    end
  end
  evr_turn u_t3 (.clk(clk), .en(adv), .a(a3), .b(b3), .s(s3), .c(c3),
                 .na(na3), .nb(nb3));
  always_ff @(posedge clk) begin
    if (adv) begin
      p3x_r[0] <= x2; p3z_r[0] <= z2;
      p3x_r[1] <= p3x_r[0]; p3z_r[1] <= p3z_r[0];
      ord5_r <= ord4_r; ord6_r <= ord5_r;
    end
  end
  logic signed [CW-1:0] x3, y3, z3;
  always_comb begin
    if (!ord6_r) begin
      x3 = na3; y3 = nb3; z3 = p3z_r[1];
    end else begin
      x3 = p3x_r[1]; y3 = na3; z3 = nb3;
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] hi, lo;
    hi = CW'(33'sh0_7FFF_FFFF);
    lo = -CW'(33'sh0_8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rot_x <= sat32(x3);
      out_rot_y <= sat32(y3);
      out_rot_z <= sat32(z3);
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rot_x) && $stable(out_rot_y)
      && $stable(out_rot_z))
    else $error("result changed while stalled");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output slot");
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("pipeline moved during stall");
  a_pipe_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted item not tracked");
`endif

endmodule

[tb/euler_vector_rotation_tb.sv]
`timescale 1ns / 100ps

module euler_vector_rotation_tb;

  localparam int STEPS = 24;
  localparam int PIPE_LATENCY = STEPS + 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_SHOWN = 10;
  localparam int RANDOM_ITEMS = 600;

  localparam logic ORDER_XYZ = 1'b0;
  localparam logic ORDER_ZYX = 1'b1;

  // One input item, and one rotated vector as the block should return it.
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } vec_item_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
  } rot_vec_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] in_vec_x, in_vec_y, in_vec_z;
  logic signed [15:0] in_angle_x, in_angle_y, in_angle_z;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_rot_x, out_rot_y, out_rot_z;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  euler_vector_rotation #(.CORDIC_STEPS(STEPS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rot_x(out_rot_x), .out_rot_y(out_rot_y), .out_rot_z(out_rot_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // The predictor's copy of the rotation order register.
  logic order_shadow;

  // Items waiting for the driver, and rotated vectors waiting for the monitor.
  vec_item_t pending_items[$];
  rot_vec_t expected_rots[$];

  int mismatches;
  int items_sent;
  int results_seen;
  int idle_cycles;
  bit hold_active;
  int hold_count;
  bit no_idle;

  // Arctangent of 2^-i in units where 2^32 is a full turn.
  localparam logic [31:0] ATAN_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sine and cosine in Q2.30 from a rotation-mode CORDIC. Angles in the back
  // half circle are turned by pi first and the results negated afterwards.
  task automatic cordic_sin_cos(input logic [15:0] ang, output longint s,
                                output longint c);
    logic [31:0] a;
    bit flip;
    longint x, y, z, nx, xs, ys;
    a = {ang, 16'h0000};
    flip = a[31] ^ a[30];
    if (flip) a = a + 32'h80000000;
    x = 652032874;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        nx = x - ys; y = y + xs; z = z - longint'(ATAN_STEP[i]);
      end else begin
        nx = x + ys; y = y - xs; z = z + longint'(ATAN_STEP[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // One plane rotation: a' = a*c - b*s, b' = a*s + b*c, rounded half up.
  task automatic plane_turn(inout longint a, inout longint b, input longint s,
                            input longint c);
    longint na, nb;
    na = (a * c - b * s + 64'sd536870912) >>> 30;
    nb = (a * s + b * c + 64'sd536870912) >>> 30;
    a = clamp64(na, -64'sd4294967295, 64'sd4294967295);
    b = clamp64(nb, -64'sd4294967295, 64'sd4294967295);
  endtask

  task automatic predict_rotation(input vec_item_t it, output rot_vec_t r);
    longint x, y, z, sx, cx, sy, cy, sz, cz;
    x = it.vx; y = it.vy; z = it.vz;
    cordic_sin_cos(it.ax, sx, cx);
    cordic_sin_cos(it.ay, sy, cy);
    cordic_sin_cos(it.az, sz, cz);
    if (order_shadow == ORDER_XYZ) begin
      plane_turn(y, z, sx, cx);
      plane_turn(z, x, sy, cy);
      plane_turn(x, y, sz, cz);
    end else begin
      plane_turn(x, y, sz, cz);
      plane_turn(z, x, sy, cy);
      plane_turn(y, z, sx, cx);
    end
    r.rx = 32'(clamp64(x, -64'sd2147483648, 64'sd2147483647));
    r.ry = 32'(clamp64(y, -64'sd2147483648, 64'sd2147483647));
    r.rz = 32'(clamp64(z, -64'sd2147483648, 64'sd2147483647));
  endtask

  function automatic vec_item_t random_item();
    vec_item_t it;
    int pick;
    it.ax = 16'($urandom); it.ay = 16'($urandom); it.az = 16'($urandom);
    pick = $urandom_range(0, 3);
    // Mostly moderate vectors; the rest uses full-scale values so that the
    // final saturation gets its share.
    if (pick == 0) begin
      it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
    end else begin
      it.vx = $signed($urandom) >>> $urandom_range(1, 20);
      it.vy = $signed($urandom) >>> $urandom_range(1, 20);
      it.vz = $signed($urandom) >>> $urandom_range(1, 20);
    end
    return it;
  endfunction

  // Driver: presents the head of the pending queue. The payload stays put
  // while stalled, and valid only drops after a transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) items_sent <= items_sent + 1;
      if (!in_valid || !in_stall) begin
        if (in_valid && !in_stall) void'(pending_items.pop_front());
        if (pending_items.size() > 0
            && (no_idle || $urandom_range(0, 99) >= 23)) begin
          vec_item_t nxt;
          nxt = pending_items[0];
          in_valid <= 1'b1;
          {in_vec_x, in_vec_y, in_vec_z, in_angle_x, in_angle_y, in_angle_z} <= nxt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random idling, plus a long hold-off when asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_count <= 0;
    end else if (hold_active && hold_count < 200) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 23);
    end
  end

  // Monitor: checks every result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_rots.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_SHOWN)
          $display("Unexpected result: %0d %0d %0d", out_rot_x, out_rot_y, out_rot_z);
      end else begin
        rot_vec_t want;
        want = expected_rots.pop_front();
        if (want.rx !== out_rot_x || want.ry !== out_rot_y || want.rz !== out_rot_z)
        begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_SHOWN)
            $display("Mismatch: expected (%0d %0d %0d), got (%0d %0d %0d)",
                     want.rx, want.ry, want.rz, out_rot_x, out_rot_y, out_rot_z);
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer on the input, result or configuration channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_rots.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Queue an item for the driver and predict its rotated vector now, since
  // the order register only changes while the block is idle.
  task automatic queue_item(input vec_item_t it);
    rot_vec_t r;
    predict_rotation(it, r);
    expected_rots.push_back(r);
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_rots.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_order(input logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    order_shadow = value;
  endtask

  task automatic run_phase(input logic order, input int count);
    vec_item_t it;
    write_order(order);
    // Directed extremes: zero and full-scale vectors, angle edges.
    it = '0; queue_item(it);
    it = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    queue_item(it);
    it = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh8000, 16'sh8000};
    queue_item(it);
    it = '{32'sh00010000, 32'sh00020000, 32'sh00030000, 16'sh4000, 16'shC000, 16'sh2000};
    queue_item(it);
    it = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh00000000, 16'sh0000, 16'sh4000, 16'sh6000};
    queue_item(it);
    it = '{32'shFFFFFFFF, 32'sh00000001, 32'sh7FFFFFFF, 16'shFFFF, 16'sh0001, 16'shA000};
    queue_item(it);
    for (int i = 0; i < count; i++) queue_item(random_item());
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_vec_x = '0; in_vec_y = '0; in_vec_z = '0;
    in_angle_x = '0; in_angle_y = '0; in_angle_z = '0;
    out_stall = 1'b0;
    order_shadow = ORDER_XYZ;
    mismatches = 0; items_sent = 0; results_seen = 0; idle_cycles = 0;
    hold_active = 0; no_idle = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset order first, then both settings with random traffic.
    run_phase(ORDER_XYZ, RANDOM_ITEMS / 4);
    run_phase(ORDER_ZYX, RANDOM_ITEMS / 4);

    // Long stretch with no idling on either side.
    no_idle = 1;
    run_phase(ORDER_XYZ, RANDOM_ITEMS / 4);
    no_idle = 0;

    // The receiver holds off while the sender keeps offering, so the
    // pipeline fills and the input stalls.
    hold_active = 1;
    run_phase(ORDER_ZYX, RANDOM_ITEMS / 4);
    hold_active = 0;

    $display("Sent %0d vectors and checked %0d rotated results over both orders,",
             items_sent, results_seen);
    $display("with random idling, a no-idle stretch and a long receiver hold-off.");
    if (mismatches == 0 && expected_rots.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
